// ----- rtl/bcmc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the converter mode controller.
// Holds the transaction structs, mode and register codes, and reset values.
// Depends on nothing; every other file in rtl imports it.

package bcmc_pkg;

	// Number formats: voltages Q2.14, duties Q1.15.
	localparam int VOLTAGE_BITS   = 16;
	localparam int DUTY_FRAC_BITS = 15;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 3;

	// The quotient holds a voltage shifted up by the duty fraction.
	localparam int QUOT_W = VOLTAGE_BITS + DUTY_FRAC_BITS;

	// One percent of unity (1.0) in the voltage format, rounded to nearest.
	localparam int GUARD_LEVEL = ((1 << (VOLTAGE_BITS - 2)) + 50) / 100;

	// Unity duty in Q1.15.
	localparam logic [CFG_W-1:0] DUTY_ONE = CFG_W'(1 << DUTY_FRAC_BITS);

	// Register reset values.
	localparam logic [CFG_W-1:0] RST_PWM_PERIOD       = 16'd1000;
	localparam logic [CFG_W-1:0] RST_ENTRY_LEVEL      = 16'd819;
	localparam logic [CFG_W-1:0] RST_PRECHARGE_TARGET = 16'd3277;
	localparam logic [CFG_W-1:0] RST_PRECHARGE_STEP   = 16'd328;
	localparam logic [CFG_W-1:0] RST_MIN_ACTIVE_DUTY  = 16'd1638;
	localparam logic [CFG_W-1:0] RST_MAX_ACTIVE_DUTY  = 16'd31130;

	typedef enum logic [1:0] {
		MODE_IDLE      = 2'd0,
		MODE_PRECHARGE = 2'd1,
		MODE_ACTIVE    = 2'd2,
		MODE_FAULT     = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PWM_PERIOD       = 3'd0,
		REG_ENTRY_LEVEL      = 3'd1,
		REG_PRECHARGE_TARGET = 3'd2,
		REG_PRECHARGE_STEP   = 3'd3,
		REG_MIN_ACTIVE_DUTY  = 3'd4,
		REG_MAX_ACTIVE_DUTY  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [VOLTAGE_BITS-1:0] pack_voltage;
		logic [VOLTAGE_BITS-1:0] bus_voltage;
		logic                    break_in_fault;
		logic                    over_temp_fault;
		logic                    fault_notice;
		logic                    power_direction;
	} tick_t;

	typedef struct packed {
		logic             pwm_enable;
		logic [CFG_W-1:0] ticks_phase_a;
		logic [CFG_W-1:0] ticks_phase_b;
		logic [1:0]       mode;
	} result_t;

endpackage

// ----- rtl/bcmc_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per clock, for the voltage ratio.
// Computes (numer << DUTY_FRAC_BITS) / denom; depends on bcmc_pkg.

module bcmc_div import bcmc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [VOLTAGE_BITS-1:0] numer,
	input  logic [VOLTAGE_BITS-1:0] denom,
	output logic                    done,
	output logic [QUOT_W-1:0]       quotient
);

	localparam int CNT_W = $clog2(QUOT_W);

	logic [QUOT_W-1:0]       dq_q;
	logic [VOLTAGE_BITS-1:0] rem_q;
	logic [VOLTAGE_BITS-1:0] den_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;

	logic [VOLTAGE_BITS:0] trial;
	logic [VOLTAGE_BITS:0] diff;
	logic                  fits;

	// Bring down the next dividend bit and try a subtraction.
	assign trial = {rem_q, dq_q[QUOT_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= {numer, {DUTY_FRAC_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= fits ? diff[VOLTAGE_BITS-1:0] : trial[VOLTAGE_BITS-1:0];
			dq_q  <= {dq_q[QUOT_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

// ----- rtl/bidirectional_converter_mode_control.sv -----
`timescale 1ns / 1ps
// Top level of the bidirectional converter mode controller.
// Uses bcmc_pkg for types and constants and bcmc_div for the voltage ratio.

// One tick transaction yields exactly one result transaction. A tick that
// is handled in idle, precharge or fault mode goes from the scale state to
// the output state. A tick handled in active mode runs the voltage ratio
// through a restoring divider that retires one quotient bit per cycle over
// 31 bits, then goes through the clamp, scale and output states; the
// near-zero voltage guard skips the division and goes straight to clamp.
// The output state loads the result once the slot is free or being emptied.
// tick_ready is high whenever the sequencer is waiting for work, even while
// an earlier result still waits to be taken. Register writes are taken on
// any cycle with cfg_wr_en high and must only be issued while the block is
// idle; unknown indexes are ignored. A fault latches until reset.

module bidirectional_converter_mode_control import bcmc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_valid,
	output logic                 tick_ready,
	input  tick_t                tick,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int PROD_W  = 2 * CFG_W + 1;
	localparam int SCALE_W = PROD_W - DUTY_FRAC_BITS;

	typedef enum logic [2:0] {
		ST_WAIT,
		ST_DIV,
		ST_CLAMP,
		ST_SCALE,
		ST_OUT
	} state_t;

	state_t  state_q;
	mode_t   mode_q;
	logic    dir_q;
	logic    enable_q;
	logic [CFG_W-1:0] duty_q;
	logic    result_valid_q;
	result_t result_q;

	logic [CFG_W-1:0] pwm_period_q;
	logic [CFG_W-1:0] entry_level_q;
	logic [CFG_W-1:0] precharge_target_q;
	logic [CFG_W-1:0] precharge_step_q;
	logic [CFG_W-1:0] min_active_duty_q;
	logic [CFG_W-1:0] max_active_duty_q;

	logic             guard_q;
	logic [CFG_W-1:0] guard_val_q;
	logic [PROD_W-1:0] prod_q;

	logic             accept;
	logic             result_load;
	mode_t            handler_mode;
	mode_t            next_mode;
	logic             next_enable;
	logic [CFG_W-1:0] handler_duty;
	logic [CFG_W-1:0] duty_base;
	logic [CFG_W:0]   ramp;
	logic             above_entry;

	logic [VOLTAGE_BITS-1:0] div_numer;
	logic [VOLTAGE_BITS-1:0] div_denom;
	logic                    guard;
	logic                    div_start;
	logic                    div_done;
	logic [QUOT_W-1:0]       div_quot;

	logic [QUOT_W-1:0]  clamp_src;
	logic [CFG_W-1:0]   clamped;
	logic [CFG_W-1:0]   duty_lim;
	logic [CFG_W:0]     period_p1;
	logic [PROD_W-1:0]  prod_d;
	logic [SCALE_W-1:0] scaled;
	logic [CFG_W-1:0]   ticks;

	assign tick_ready = (state_q == ST_WAIT);
	assign accept     = tick_valid && tick_ready;

	// The result register takes a new transaction once its slot is free or being emptied.
	assign result_load = (state_q == ST_OUT) && (!result_valid_q || result_ready);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q       <= RST_PWM_PERIOD;
			entry_level_q      <= RST_ENTRY_LEVEL;
			precharge_target_q <= RST_PRECHARGE_TARGET;
			precharge_step_q   <= RST_PRECHARGE_STEP;
			min_active_duty_q  <= RST_MIN_ACTIVE_DUTY;
			max_active_duty_q  <= RST_MAX_ACTIVE_DUTY;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_PWM_PERIOD:       pwm_period_q       <= cfg_data;
				REG_ENTRY_LEVEL:      entry_level_q      <= cfg_data;
				REG_PRECHARGE_TARGET: precharge_target_q <= cfg_data;
				REG_PRECHARGE_STEP:   precharge_step_q   <= cfg_data;
				REG_MIN_ACTIVE_DUTY:  min_active_duty_q  <= cfg_data;
				REG_MAX_ACTIVE_DUTY:  max_active_duty_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Mode decision for the offered tick: faults, direction change, handler.
	always_comb begin
		handler_mode = mode_q;
		duty_base    = duty_q;
		if (tick.fault_notice) begin
			handler_mode = MODE_FAULT;
		end
		if ((tick.power_direction != dir_q) && (handler_mode == MODE_ACTIVE)) begin
			handler_mode = MODE_PRECHARGE;
			duty_base    = '0;
		end
		if (tick.break_in_fault || tick.over_temp_fault) begin
			handler_mode = MODE_FAULT;
		end

		above_entry = (tick.pack_voltage > entry_level_q) ||
			(tick.bus_voltage > entry_level_q);
		ramp         = {1'b0, duty_base} + {1'b0, precharge_step_q};
		next_mode    = handler_mode;
		next_enable  = 1'b0;
		handler_duty = '0;

		case (handler_mode)
			MODE_IDLE: begin
				if (!tick.break_in_fault && above_entry) begin
					next_mode = MODE_PRECHARGE;
				end
			end
			MODE_PRECHARGE: begin
				next_enable  = 1'b1;
				handler_duty = (ramp > {1'b0, precharge_target_q}) ?
					precharge_target_q : ramp[CFG_W-1:0];
				if ((handler_duty >= precharge_target_q) && !tick.break_in_fault) begin
					next_mode = MODE_ACTIVE;
				end
			end
			MODE_ACTIVE: begin
				next_enable = 1'b1;
				if (!above_entry) begin
					next_mode = MODE_IDLE;
				end
			end
			default: begin
				next_mode = MODE_FAULT;
			end
		endcase
	end

	// Ratio operands follow the wanted direction: buck pack/bus, boost bus/pack.
	assign div_numer = tick.power_direction ? tick.bus_voltage  : tick.pack_voltage;
	assign div_denom = tick.power_direction ? tick.pack_voltage : tick.bus_voltage;
	assign guard     = div_denom <= VOLTAGE_BITS'(GUARD_LEVEL);
	assign div_start = accept && (handler_mode == MODE_ACTIVE) && !guard;

	bcmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (div_numer),
		.denom    (div_denom),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Active clamp; the lower bound is tested first.
	assign clamp_src = guard_q ? QUOT_W'(guard_val_q) : div_quot;
	always_comb begin
		if (clamp_src < QUOT_W'(min_active_duty_q)) begin
			clamped = min_active_duty_q;
		end else if (clamp_src > QUOT_W'(max_active_duty_q)) begin
			clamped = max_active_duty_q;
		end else begin
			clamped = clamp_src[CFG_W-1:0];
		end
	end

	// Duty to compare ticks: limit to unity, scale by period plus one, cap.
	assign duty_lim  = (duty_q > DUTY_ONE) ? DUTY_ONE : duty_q;
	assign period_p1 = {1'b0, pwm_period_q} + 1'b1;
	assign prod_d    = PROD_W'(duty_lim) * PROD_W'(period_p1);
	assign scaled    = prod_q[PROD_W-1:DUTY_FRAC_BITS];
	always_comb begin
		if (pwm_period_q == '0) begin
			ticks = '0;
		end else if (scaled > SCALE_W'(pwm_period_q)) begin
			ticks = pwm_period_q;
		end else begin
			ticks = scaled[CFG_W-1:0];
		end
	end

	// Working values that need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			guard_q     <= guard;
			guard_val_q <= tick.power_direction ? max_active_duty_q : min_active_duty_q;
		end
		if (state_q == ST_SCALE) begin
			prod_q <= prod_d;
		end
	end

	// Sequencer, controller state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_WAIT;
			mode_q         <= MODE_IDLE;
			dir_q          <= 1'b0;
			duty_q         <= '0;
			enable_q       <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_WAIT: begin
					if (tick_valid) begin
						mode_q   <= next_mode;
						dir_q    <= tick.power_direction;
						enable_q <= next_enable;
						if (handler_mode == MODE_ACTIVE) begin
							state_q <= guard ? ST_CLAMP : ST_DIV;
						end else begin
							duty_q  <= handler_duty;
							state_q <= ST_SCALE;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					duty_q  <= clamped;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// Load the result once the output slot is free or being emptied.
					if (result_load) begin
						result_q.pwm_enable    <= enable_q;
						result_q.ticks_phase_a <= ticks;
						result_q.ticks_phase_b <= ticks;
						result_q.mode          <= mode_q;
						state_q                <= ST_WAIT;
					end
				end
				default: begin
					state_q <= ST_WAIT;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/bcmc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the converter mode controller, bound to the top level.
// Depends on bcmc_pkg and bidirectional_converter_mode_control.

module bcmc_checker import bcmc_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    tick_valid,
	input logic    tick_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	logic fault_seen_q;

	// Remember that a fault result has been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_seen_q <= 1'b0;
		end else if (result_valid && result_ready && (result.mode == MODE_FAULT)) begin
			fault_seen_q <= 1'b1;
		end
	end

	// A stalled result transaction holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Once fault has been reported, every later result stays in fault.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && fault_seen_q |-> result.mode == MODE_FAULT)
		else $error("left fault mode without reset");

	// With PWM disabled the duty is zero, so both compare values are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.pwm_enable |->
			result.ticks_phase_a == '0 && result.ticks_phase_b == '0)
		else $error("non-zero compare value with PWM disabled");

	// Both phases always carry the same compare value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.ticks_phase_a == result.ticks_phase_b)
		else $error("phase compare values differ");

	// An accepted tick occupies the sequencer for at least the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !tick_ready)
		else $error("ready did not drop after a tick transaction");

endmodule

bind bidirectional_converter_mode_control bcmc_checker u_bcmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_valid   (tick_valid),
	.tick_ready   (tick_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the converter mode controller, one result per tick.
// A scoreboard class tracks mode, direction and duty to predict every result.
// Depends on rtl/bcmc_pkg.sv and rtl/bidirectional_converter_mode_control.sv.

module tb_top;
	import bcmc_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int MAX_REPORTED = 10;
	localparam int HOLD_CYCLES  = 400;
	localparam int END_SETTLE   = 40;

	// Indexes that decode to no register; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [CFG_W-1:0] period, entry_level, target, step, min_duty, max_duty;
	} settings_t;

	// Tracks the controller state and holds the results still owed by the block.
	class converter_scoreboard;
		settings_t   cfg;
		mode_t       mode_q;
		logic        dir_q;
		logic [31:0] duty_q;
		result_t     due_results[$];
		int          failures;
		int          results_seen;

		function new();
			cfg = settings_t'{RST_PWM_PERIOD, RST_ENTRY_LEVEL, RST_PRECHARGE_TARGET,
				RST_PRECHARGE_STEP, RST_MIN_ACTIVE_DUTY, RST_MAX_ACTIVE_DUTY};
			mode_q = MODE_IDLE;
			dir_q = 1'b0;
			duty_q = '0;
			failures = 0;
			results_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_PWM_PERIOD:       cfg.period = v;
				REG_ENTRY_LEVEL:      cfg.entry_level = v;
				REG_PRECHARGE_TARGET: cfg.target = v;
				REG_PRECHARGE_STEP:   cfg.step = v;
				REG_MIN_ACTIVE_DUTY:  cfg.min_duty = v;
				REG_MAX_ACTIVE_DUTY:  cfg.max_duty = v;
				default: ;
			endcase
		endfunction

		// Active duty: the voltage ratio for the held direction, guarded and clamped.
		function logic [31:0] voltage_ratio(logic [VOLTAGE_BITS-1:0] pack,
				logic [VOLTAGE_BITS-1:0] bus);
			longint unsigned q;
			if (dir_q == 1'b0) begin
				if (bus <= GUARD_LEVEL)
					q = cfg.min_duty;
				else
					q = (longint'(pack) << DUTY_FRAC_BITS) / bus;
			end else begin
				if (pack <= GUARD_LEVEL)
					q = cfg.max_duty;
				else
					q = (longint'(bus) << DUTY_FRAC_BITS) / pack;
			end
			if (q < cfg.min_duty)
				q = cfg.min_duty;
			else if (q > cfg.max_duty)
				q = cfg.max_duty;
			return q[31:0];
		endfunction

		// Advances the controller by one accepted tick and queues the result it owes.
		function void advance_tick(tick_t t);
			result_t         r;
			logic [31:0]     raised;
			longint unsigned d, ticks;
			r = '0;
			if (t.fault_notice)
				mode_q = MODE_FAULT;
			// A direction change while active restarts the ramp from zero.
			if (t.power_direction != dir_q) begin
				dir_q = t.power_direction;
				if (mode_q == MODE_ACTIVE) begin
					mode_q = MODE_PRECHARGE;
					duty_q = '0;
				end
			end
			if (t.break_in_fault || t.over_temp_fault)
				mode_q = MODE_FAULT;
			case (mode_q)
				MODE_IDLE: begin
					duty_q = '0;
					if (!t.break_in_fault && (t.pack_voltage > cfg.entry_level ||
							t.bus_voltage > cfg.entry_level))
						mode_q = MODE_PRECHARGE;
				end
				MODE_PRECHARGE: begin
					r.pwm_enable = 1'b1;
					raised = duty_q + cfg.step;
					duty_q = (raised > cfg.target) ? 32'(cfg.target) : raised;
					if (duty_q >= cfg.target && !t.break_in_fault)
						mode_q = MODE_ACTIVE;
				end
				MODE_ACTIVE: begin
					r.pwm_enable = 1'b1;
					duty_q = voltage_ratio(t.pack_voltage, t.bus_voltage);
					if (t.pack_voltage <= cfg.entry_level && t.bus_voltage <= cfg.entry_level)
						mode_q = MODE_IDLE;
				end
				default: begin
					mode_q = MODE_FAULT;
					duty_q = '0;
				end
			endcase
			// Scale the duty, saturated at one, to compare ticks within the period.
			ticks = 0;
			if (cfg.period != 0) begin
				d = duty_q;
				if (d > DUTY_ONE)
					d = DUTY_ONE;
				ticks = (d * (longint'(cfg.period) + 1)) >> DUTY_FRAC_BITS;
				if (ticks > cfg.period)
					ticks = cfg.period;
			end
			r.ticks_phase_a = ticks[CFG_W-1:0];
			r.ticks_phase_b = ticks[CFG_W-1:0];
			r.mode = mode_q;
			due_results.push_back(r);
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= MAX_REPORTED)
				$display("%s", msg);
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_seen++;
			if (due_results.size() == 0) begin
				note_failure($sformatf("result %0d arrived with none due: en=%0b a=%0d b=%0d mode=%0d",
					results_seen, got.pwm_enable, got.ticks_phase_a, got.ticks_phase_b, got.mode));
				return;
			end
			want = due_results.pop_front();
			if (got.pwm_enable !== want.pwm_enable || got.ticks_phase_a !== want.ticks_phase_a ||
					got.ticks_phase_b !== want.ticks_phase_b || got.mode !== want.mode)
				note_failure($sformatf({"result %0d: expected en=%0b a=%0d b=%0d mode=%0d, ",
					"got en=%0b a=%0d b=%0d mode=%0d"}, results_seen,
					want.pwm_enable, want.ticks_phase_a, want.ticks_phase_b, want.mode,
					got.pwm_enable, got.ticks_phase_a, got.ticks_phase_b, got.mode));
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 tick_valid;
	logic                 tick_ready;
	tick_t                tick;
	logic                 result_valid;
	logic                 result_ready;
	result_t              result;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	converter_scoreboard board;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int cycle_count;

	bidirectional_converter_mode_control dut (
		.clk, .arst_n, .tick_valid, .tick_ready, .tick, .result_valid, .result_ready,
		.result, .cfg_wr_en, .cfg_index, .cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Give up once the run exceeds the cycle limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("bidirectional_converter_mode_control test failed");
		$finish;
	end

	// Result side: ready toggles at random, with an occasional long hold-off.
	initial begin
		int hold_left;
		hold_left = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				result_ready = 1'b0;
				hold_left--;
			end else begin
				result_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Every result transaction is checked on the edge that accepts it.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready)
				board.check_result(result);
		end
	end

	// Idling regimes: receiver lazy, sender lazy, or both eager.
	task automatic set_regime(input int regime);
		case (regime)
			0: begin
				send_idle_pct = 10;
				recv_idle_pct = 73;
			end
			1: begin
				send_idle_pct = 73;
				recv_idle_pct = 10;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Offers one tick transaction; entered and left at a falling edge.
	task automatic send_tick(input tick_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			tick_valid = 1'b0;
			@(negedge clk);
		end
		tick_valid = 1'b1;
		tick = t;
		@(posedge clk);
		while (!tick_ready)
			@(posedge clk);
		board.advance_tick(t);
		@(negedge clk);
	endtask

	task automatic drain_results();
		tick_valid = 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		board.write_reg(idx, v);
		@(negedge clk);
	endtask

	// Writes every register; the spare indexes go last so any aliasing shows.
	task automatic apply_settings(input settings_t s);
		cfg_write(REG_PWM_PERIOD, s.period);
		cfg_write(REG_ENTRY_LEVEL, s.entry_level);
		cfg_write(REG_PRECHARGE_TARGET, s.target);
		cfg_write(REG_PRECHARGE_STEP, s.step);
		cfg_write(REG_MIN_ACTIVE_DUTY, s.min_duty);
		cfg_write(REG_MAX_ACTIVE_DUTY, s.max_duty);
		cfg_write(REG_SPARE_LO, CFG_W'($urandom));
		cfg_write(REG_SPARE_HI, CFG_W'($urandom));
		cfg_wr_en = 1'b0;
	endtask

	function automatic tick_t make_tick(input logic [VOLTAGE_BITS-1:0] pack,
			input logic [VOLTAGE_BITS-1:0] bus, input logic dir);
		tick_t t;
		t = '0;
		t.pack_voltage = pack;
		t.bus_voltage = bus;
		t.power_direction = dir;
		return t;
	endfunction

	// Voltages bunch around the guard level, the entry threshold and full scale.
	function automatic logic [VOLTAGE_BITS-1:0] pick_voltage(input logic [CFG_W-1:0] entry);
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return VOLTAGE_BITS'($urandom_range(GUARD_LEVEL + 2));
		if (r < 16)
			return VOLTAGE_BITS'($urandom_range(entry));
		if (r < 22)
			return entry + VOLTAGE_BITS'($urandom_range(1));
		if (r < 30)
			return 16'hFFFF - VOLTAGE_BITS'($urandom_range(3));
		return VOLTAGE_BITS'($urandom_range(65535));
	endfunction

	// Fault-free ticks: mostly a steady direction, with some unrelated noise.
	function automatic tick_t random_tick(input logic [CFG_W-1:0] entry, input logic dir_now);
		tick_t t;
		t = '0;
		if ($urandom_range(99) < 15) begin
			t.pack_voltage = VOLTAGE_BITS'($urandom);
			t.bus_voltage = VOLTAGE_BITS'($urandom);
			t.power_direction = 1'($urandom_range(1));
		end else begin
			t.pack_voltage = pick_voltage(entry);
			t.bus_voltage = pick_voltage(entry);
			t.power_direction = ($urandom_range(99) < 6) ? ~dir_now : dir_now;
		end
		return t;
	endfunction

	function automatic settings_t random_settings();
		settings_t        s;
		logic [CFG_W-1:0] lo, hi;
		case ($urandom_range(3))
			0:       s.period = '0;
			1:       s.period = 16'hFFFF;
			default: s.period = CFG_W'($urandom_range(65535));
		endcase
		s.entry_level = CFG_W'($urandom_range(8000));
		s.target = CFG_W'($urandom_range(32768));
		s.step = CFG_W'($urandom_range(64, 32768));
		lo = CFG_W'($urandom_range(16384));
		hi = CFG_W'($urandom_range(16384, 32768));
		// Now and then the clamps are inverted.
		if ($urandom_range(4) == 0) begin
			s.min_duty = hi;
			s.max_duty = lo;
		end else begin
			s.min_duty = lo;
			s.max_duty = hi;
		end
		return s;
	endfunction

	// One phase of random ticks under one setting, with optional pressure points.
	task automatic run_phase(input settings_t s, input int regime, input int count,
			input int hold_at, input int pause_at);
		drain_results();
		apply_settings(s);
		set_regime(regime);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_request = HOLD_CYCLES;
			if (i == pause_at)
				drain_results();
			send_tick(random_tick(board.cfg.entry_level, board.dir_q));
		end
	endtask

	initial begin
		tick_t t;
		board = new();
		arst_n = 1'b0;
		tick_valid = 1'b0;
		tick = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		set_regime(0);

		// Reset settings: idle at and above the threshold, the ramp, buck cases.
		send_tick(make_tick(16'd0, 16'd0, 1'b0));
		send_tick(make_tick(16'd819, 16'd819, 1'b0));
		send_tick(make_tick(16'd820, 16'd0, 1'b0));
		repeat (10) send_tick(make_tick(16'd16384, 16'd16384, 1'b0));
		send_tick(make_tick(16'd16384, 16'd32768, 1'b0));
		send_tick(make_tick(16'd16384, 16'd164, 1'b0));
		send_tick(make_tick(16'd16384, 16'd165, 1'b0));
		send_tick(make_tick(16'd0, 16'd65535, 1'b0));
		send_tick(make_tick(16'd65535, 16'd65535, 1'b0));
		// Turning to boost while active drops back into precharge.
		send_tick(make_tick(16'd16384, 16'd16384, 1'b1));

		// Full-scale period and wide clamps: boost guard, full duty and the way to idle.
		drain_results();
		apply_settings(settings_t'{16'hFFFF, 16'd819, 16'd32768, 16'd32768, 16'd0, 16'd32768});
		send_tick(make_tick(16'd16384, 16'd16384, 1'b1));
		send_tick(make_tick(16'd164, 16'd16384, 1'b1));
		send_tick(make_tick(16'd165, 16'd65535, 1'b1));
		send_tick(make_tick(16'd65535, 16'd0, 1'b1));
		send_tick(make_tick(16'd32768, 16'd16384, 1'b1));
		send_tick(make_tick(16'd819, 16'd819, 1'b1));
		send_tick(make_tick(16'd0, 16'd0, 1'b1));

		// Random phases over a spread of settings and idling regimes.
		run_phase(settings_t'{RST_PWM_PERIOD, RST_ENTRY_LEVEL, RST_PRECHARGE_TARGET,
			RST_PRECHARGE_STEP, RST_MIN_ACTIVE_DUTY, RST_MAX_ACTIVE_DUTY}, 0, 350, 120, -1);
		// Zero period, zero target and step, inverted clamps.
		run_phase(settings_t'{16'd0, 16'd0, 16'd0, 16'd0, 16'd32768, 16'd0}, 0, 250, -1, -1);
		// A threshold no voltage can pass keeps the block idle.
		run_phase(settings_t'{16'hFFFF, 16'hFFFF, 16'd32768, 16'd1, 16'd0, 16'd32768},
			1, 60, -1, -1);
		run_phase(settings_t'{16'd1, 16'd10000, 16'd32768, 16'd1000, 16'd0, 16'd32768},
			1, 300, -1, 150);
		run_phase(random_settings(), 1, 300, -1, -1);
		run_phase(random_settings(), 2, 300, 100, -1);
		run_phase(random_settings(), 2, 250, -1, -1);

		// A fault latches until reset, so it comes last; every flag then goes random.
		t = random_tick(board.cfg.entry_level, board.dir_q);
		case ($urandom_range(2))
			0:       t.fault_notice = 1'b1;
			1:       t.break_in_fault = 1'b1;
			default: t.over_temp_fault = 1'b1;
		endcase
		send_tick(t);
		repeat (50) begin
			t.pack_voltage = VOLTAGE_BITS'($urandom);
			t.bus_voltage = VOLTAGE_BITS'($urandom);
			{t.break_in_fault, t.over_temp_fault, t.fault_notice, t.power_direction} =
				4'($urandom);
			send_tick(t);
		end

		drain_results();
		repeat (END_SETTLE) @(negedge clk);
		if (board.pending() != 0)
			board.note_failure($sformatf("%0d results never arrived", board.pending()));
		if (board.failures == 0)
			$display("bidirectional_converter_mode_control test passed");
		else
			$display("bidirectional_converter_mode_control test failed");
		$finish;
	end

endmodule
